/* sv/image_convolution_3x3_clamped_macros.svh */
// Assertion macros shared by the convolution block.
`ifndef IMAGE_CONVOLUTION_3X3_CLAMPED_MACROS_SVH
`define IMAGE_CONVOLUTION_3X3_CLAMPED_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ICV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ICV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/icv_pkg.sv */
package icv_pkg;

    localparam int KERNEL_SIZE   = 3;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int FIFO_DEPTH    = 4;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_COEFF_TOP    = 3'd0;
    localparam logic [2:0] REG_COEFF_MID    = 3'd1;
    localparam logic [2:0] REG_COEFF_BOTTOM = 3'd2;
    localparam logic [2:0] REG_GAIN         = 3'd3;
    localparam logic [2:0] REG_BASE_COLOR   = 3'd4;
    localparam logic [2:0] REG_LAST_COLOR   = 3'd5;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd6;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd7;

    localparam logic [23:0] RST_COEFF_TOP    = 24'h000000;
    localparam logic [23:0] RST_COEFF_MID    = 24'h000100;
    localparam logic [23:0] RST_COEFF_BOTTOM = 24'h000000;
    localparam logic [7:0]  RST_GAIN         = 8'd1;
    localparam logic [7:0]  RST_BASE_COLOR   = 8'd0;
    localparam logic [7:0]  RST_LAST_COLOR   = 8'd255;
    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd320;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd256;

    localparam int PROD_W = 17;
    localparam int SUM_W  = 20;
    localparam int VAL_W  = 28;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic [7:0] pixel;
        logic       emit;
        logic       last;
        logic [2:0] row_ok;
        logic [2:0] col_ok;
    } icv_item_t;

    typedef struct packed {
        logic [23:0]        coeff_top;
        logic [23:0]        coeff_mid;
        logic [23:0]        coeff_bottom;
        logic signed [7:0]  gain;
        logic [7:0]         base_color;
        logic [7:0]         last_color;
    } icv_cfg_t;

    typedef struct packed {
        logic push;
        logic last;
        logic at_origin;
    } icv_front_stat_t;

    typedef struct packed {
        logic busy;
        logic out_load;
    } icv_back_stat_t;

endpackage

/* sv/icv_fifo.sv */
module icv_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

/* sv/icv_front.sv */
module icv_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   pixel_in,
    input  logic                         fill,
    input  logic [10:0]                  image_width,
    input  logic [10:0]                  image_height,
    input  logic                         fifo_full,
    output logic                         push,
    output icv_pkg::icv_item_t           item,
    output logic [$clog2(MAX_WIDTH)-1:0] column,
    output icv_pkg::icv_front_stat_t     stat
);
    import icv_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int GW    = 14;

    logic [COL_W-1:0] col_reg;
    logic [10:0]      row_reg;
    logic [GW-1:0]    w_eff, h_eff, ic_x, ir_x, cx, cy;
    logic             restart, emit, last;
    logic [COL_W-1:0] ic;
    logic [10:0]      ir;

    always_comb
    begin
        w_eff = GW'(image_width);
        if (w_eff == '0)
        begin
            w_eff = GW'(1);
        end
        else if (w_eff > GW'(MAX_WIDTH))
        begin
            w_eff = GW'(MAX_WIDTH);
        end
        h_eff = GW'(image_height);
        if (h_eff == '0)
        begin
            h_eff = GW'(1);
        end
        else if (h_eff > GW'(MAX_HEIGHT))
        begin
            h_eff = GW'(MAX_HEIGHT);
        end
    end

    assign restart = (GW'(col_reg) >= w_eff) || (GW'(row_reg) > h_eff + GW'(1));
    assign ic      = restart ? '0 : col_reg;
    assign ir      = restart ? '0 : row_reg;
    assign ic_x    = GW'(ic);
    assign ir_x    = GW'(ir);
    assign emit    = (ir_x >= GW'(2)) || ((ir_x == GW'(1)) && (ic_x != '0));

    // The centre sits one row and one pixel behind the input position.
    assign cx = (ic_x != '0) ? ic_x - GW'(1) : w_eff - GW'(1);
    assign cy = (ic_x != '0) ? ir_x - GW'(1) : ir_x - GW'(2);
    assign last = emit && (cy == h_eff - GW'(1)) && (cx == w_eff - GW'(1));

    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full;
    assign column   = ic;

    always_comb
    begin
        item.pixel     = fill ? 8'd0 : pixel_in;
        item.emit      = emit;
        item.last      = last;
        item.row_ok[0] = (cy != '0) && (cy - GW'(1) < h_eff);
        item.row_ok[1] = (cy < h_eff);
        item.row_ok[2] = (cy + GW'(1) < h_eff);
        item.col_ok[0] = (cx != '0);
        item.col_ok[1] = 1'b1;
        item.col_ok[2] = (cx + GW'(1) < w_eff);
    end

    assign stat.push      = push;
    assign stat.last      = last;
    assign stat.at_origin = (col_reg == '0) && (row_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push)
        begin
            if (last)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (ic_x + GW'(1) >= w_eff)
            begin
                col_reg <= '0;
                row_reg <= ir + 11'd1;
            end
            else
            begin
                col_reg <= ic + 1'b1;
                row_reg <= ir;
            end
        end
    end
endmodule

/* sv/icv_back.sv */
module icv_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  icv_pkg::icv_cfg_t            cfg,
    input  logic                         fifo_empty,
    output logic                         pop,
    input  icv_pkg::icv_item_t           item,
    input  logic [$clog2(MAX_WIDTH)-1:0] column,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   out_pixel,
    output logic                         out_last,
    output icv_pkg::icv_back_stat_t      stat
);
    import icv_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WIN  = 3'd1;
    localparam logic [2:0] ST_PROD = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_GAIN = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [15:0] line_mem [MAX_WIDTH];
    logic [15:0] rd_reg;
    icv_item_t   item_reg;
    logic [COL_W-1:0] col_reg;

    logic [7:0] win_reg [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PROD_W-1:0] prod_reg [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PROD_W-1:0] prod_next [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [VAL_W-1:0]  val_reg, clamp_val, lim;
    logic [7:0] out_pixel_reg;
    logic       out_last_reg, out_valid_reg, out_load;

    assign pop      = (state_reg == ST_IDLE) && !fifo_empty;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!fifo_empty) state_next = ST_WIN;
            ST_WIN:  state_next = item_reg.emit ? ST_PROD : ST_IDLE;
            ST_PROD: state_next = ST_SUM;
            ST_SUM:  state_next = ST_GAIN;
            ST_GAIN: state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Upper line in the high byte, lower line in the low byte.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_reg <= line_mem[column];
        end
        if (state_reg == ST_WIN)
        begin
            line_mem[col_reg] <= {rd_reg[7:0], item_reg.pixel};
        end
    end

    always_comb
    begin
        logic [23:0] row_coeff;
        logic [7:0]  pix;
        row_coeff = '0;
        pix       = '0;
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            row_coeff = (r == 0) ? cfg.coeff_top : (r == 1) ? cfg.coeff_mid : cfg.coeff_bottom;
            for (int k = 0; k < KERNEL_SIZE; k++)
            begin
                pix = win_reg[r][k] - cfg.base_color;
                if (item_reg.row_ok[r] && item_reg.col_ok[k])
                begin
                    prod_next[r][k] = $signed({1'b0, pix}) * $signed(row_coeff[8*k +: 8]);
                end
                else
                begin
                    prod_next[r][k] = '0;
                end
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            for (int k = 0; k < KERNEL_SIZE; k++)
            begin
                sum_next = sum_next + SUM_W'(prod_reg[r][k]);
            end
        end
    end

    always_comb
    begin
        lim = VAL_W'($signed({1'b0, cfg.last_color}) - $signed({1'b0, cfg.base_color}));
        clamp_val = val_reg;
        if (clamp_val < 0)
        begin
            clamp_val = '0;
        end
        if (clamp_val > lim)
        begin
            clamp_val = lim;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= item;
            col_reg  <= column;
        end
        if (state_reg == ST_PROD)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= sum_next;
        end
        if (state_reg == ST_GAIN)
        begin
            val_reg <= VAL_W'(sum_reg) * VAL_W'(cfg.gain);
        end
        if (out_load)
        begin
            out_pixel_reg <= clamp_val[7:0] + cfg.base_color;
            out_last_reg  <= item_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < KERNEL_SIZE; r++)
            begin
                for (int k = 0; k < KERNEL_SIZE; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_WIN)
            begin
                for (int r = 0; r < KERNEL_SIZE; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= rd_reg[15:8];
                win_reg[1][2] <= rd_reg[7:0];
                win_reg[2][2] <= item_reg.pixel;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_pixel     = out_pixel_reg;
    assign out_last      = out_last_reg;
    assign stat.busy     = (state_reg != ST_IDLE);
    assign stat.out_load = out_load;
endmodule

/* sv/image_convolution_3x3_clamped.sv */
// An output word passes the queue and the back end states IDLE, WIN, PROD, SUM, GAIN
// and OUT, and leaves from the output register once that register is free.
// The back end takes a new word only when done with the last; a word with no result
// ends after WIN; the single-port line memory and product, sum and gain steps set this.
// Reset (rst_n, asynchronous, active low) clears control registers, counters, window and
// queue; data path registers and line memory are not cleared and need no clearing pass.
`include "image_convolution_3x3_clamped_macros.svh"

module image_convolution_3x3_clamped #(
    parameter int MAX_WIDTH = icv_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_in
    input  logic        s_tuser,   // [0] fill
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] pixel_out
    output logic        m_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import icv_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ITEM_W = $bits(icv_item_t);
    localparam int FIFO_W = COL_W + ITEM_W;

    // Configuration registers.
    logic [23:0] coeff_top_reg, coeff_mid_reg, coeff_bottom_reg;
    logic [7:0]  gain_reg, base_color_reg, last_color_reg;
    logic [10:0] image_width_reg, image_height_reg;
    logic        cfg_write;
    logic [2:0]  reg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_top_reg    <= RST_COEFF_TOP;
            coeff_mid_reg    <= RST_COEFF_MID;
            coeff_bottom_reg <= RST_COEFF_BOTTOM;
            gain_reg         <= RST_GAIN;
            base_color_reg   <= RST_BASE_COLOR;
            last_color_reg   <= RST_LAST_COLOR;
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_COEFF_TOP:    coeff_top_reg    <= pwdata[23:0];
                REG_COEFF_MID:    coeff_mid_reg    <= pwdata[23:0];
                REG_COEFF_BOTTOM: coeff_bottom_reg <= pwdata[23:0];
                REG_GAIN:         gain_reg         <= pwdata[7:0];
                REG_BASE_COLOR:   base_color_reg   <= pwdata[7:0];
                REG_LAST_COLOR:   last_color_reg   <= pwdata[7:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[10:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_COEFF_TOP:    prdata = {8'd0, coeff_top_reg};
            REG_COEFF_MID:    prdata = {8'd0, coeff_mid_reg};
            REG_COEFF_BOTTOM: prdata = {8'd0, coeff_bottom_reg};
            REG_GAIN:         prdata = {24'd0, gain_reg};
            REG_BASE_COLOR:   prdata = {24'd0, base_color_reg};
            REG_LAST_COLOR:   prdata = {24'd0, last_color_reg};
            REG_IMAGE_WIDTH:  prdata = {21'd0, image_width_reg};
            REG_IMAGE_HEIGHT: prdata = {21'd0, image_height_reg};
            default:          prdata = '0;
        endcase
    end

    icv_cfg_t cfg;
    assign cfg.coeff_top    = coeff_top_reg;
    assign cfg.coeff_mid    = coeff_mid_reg;
    assign cfg.coeff_bottom = coeff_bottom_reg;
    assign cfg.gain         = $signed(gain_reg);
    assign cfg.base_color   = base_color_reg;
    assign cfg.last_color   = last_color_reg;

    // The front end tracks the raster position, decides whether the word
    // completes a centre pixel and which taps lie inside the image.
    icv_item_t        front_item, back_item;
    logic [COL_W-1:0] front_col, back_col;
    logic             fifo_push, fifo_pop, fifo_full, fifo_empty;
    logic [FIFO_W-1:0] fifo_out;
    icv_front_stat_t  front_stat;
    icv_back_stat_t   back_stat;

    icv_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .pixel_in     (s_tdata),
        .fill         (s_tuser),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .fifo_full    (fifo_full),
        .push         (fifo_push),
        .item         (front_item),
        .column       (front_col),
        .stat         (front_stat)
    );

    // A short queue lets input keep arriving while the back end works.
    icv_fifo #(.DATA_W(FIFO_W), .DEPTH(FIFO_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data ({front_col, front_item}),
        .pop       (fifo_pop),
        .pop_data  (fifo_out),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    assign back_col  = fifo_out[FIFO_W-1:ITEM_W];
    assign back_item = icv_item_t'(fifo_out[ITEM_W-1:0]);

    // The back end updates the line memory and tap window, then, if the word emits, runs the
    // products, sum and gain one step per cycle and the clamp when the output is free.
    icv_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .fifo_empty (fifo_empty),
        .pop        (fifo_pop),
        .item       (back_item),
        .column     (back_col),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixel  (m_tdata),
        .out_last   (m_tlast),
        .stat       (back_stat)
    );

    // The output register is never loaded over a word that is still waiting.
    `ICV_ASSERT_NOW(a_out_no_overwrite, back_stat.out_load, !m_tvalid || m_tready, "output word overwritten")
    // The word that closes a frame sends the raster position back to the origin.
    `ICV_ASSERT_NEXT(a_frame_restart, front_stat.push && front_stat.last, front_stat.at_origin, "position not restarted")
    // The back end only takes a word out of the queue when it is not already busy.
    `ICV_ASSERT_NOW(a_pop_when_free, fifo_pop, !back_stat.busy && !fifo_empty, "queue popped while busy")
endmodule
